// ===== design/partition_count_exact_parts_assert.svh =====
// Assertion macros for partition_count_exact_parts.
`ifndef PARTITION_COUNT_EXACT_PARTS_ASSERT_SVH
`define PARTITION_COUNT_EXACT_PARTS_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PCEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcep assertion failed");

// Next-cycle implication, disabled while in reset.
`define PCEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcep assertion failed");

`endif

// ===== design/pcep_pkg.sv =====
package pcep_pkg;

    localparam int TOTAL_W = 8;
    localparam int PARTS_W = 3;
    localparam int COUNT_W = 32;

    localparam int PCEP_MAX_TOTAL = 255;
    localparam int PCEP_MAX_PARTS = 6;

    typedef logic [COUNT_W-1:0] count_t;

    // Stream control that travels with each row element.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } pcep_ctl_t;

endpackage

// ===== design/partition_count_exact_parts.sv =====
// Each accepted item streams from the source register through the cells to the done register.
// One item at a time: start is taken only while not busy; busy drops as done rises.
// The row streams one element per cycle through MAX_PARTS cells, so the row length sets the rate.
// Invalid requests run a one-element stream through the same cells to done.
// Reset (rst_n low, async) clears busy, done and the chain's valid bits; no clearing pass.
// The receiver cannot stall: count is valid only in the cycle done is high.
module partition_count_exact_parts
    import pcep_pkg::*;
#(
    parameter int MAX_TOTAL = PCEP_MAX_TOTAL,
    parameter int MAX_PARTS = PCEP_MAX_PARTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TOTAL_W-1:0] total,
    input  logic [PARTS_W-1:0] parts,
    output logic               busy,
    output logic               done,
    output logic [COUNT_W-1:0] count
);

    // Row index width: the stream runs over elements 0..total-parts.
    localparam int IW = (MAX_TOTAL > 1) ? $clog2(MAX_TOTAL + 1) : 1;

    logic               busy_reg;
    logic               done_reg;
    count_t             count_reg;
    logic               src_run_reg;
    logic [IW-1:0]      src_idx_reg;
    logic [IW-1:0]      m_reg;
    logic [PARTS_W-1:0] parts_reg;
    logic               zero_reg;
    pcep_ctl_t          src_ctl_reg;
    count_t             src_val_reg;

    logic               accept;
    logic               bad_req;
    logic               src_last;

    // Chain taps: index 0 is the source, MAX_PARTS is the tail.
    pcep_ctl_t          ctl_chain [MAX_PARTS+1];
    count_t             val_chain [MAX_PARTS+1];

    // Out-of-range or impossible requests yield zero; they still run a
    // one-element stream so the done timing comes from the same path.
    assign accept   = start && !busy_reg;
    assign bad_req  = (32'(parts) > MAX_PARTS) || (32'(total) > MAX_TOTAL) ||
                      ({5'b0, parts} > total);
    assign src_last = (src_idx_reg == m_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            src_run_reg <= 1'b0;
            src_ctl_reg <= '0;
        end
        else
        begin
            done_reg          <= ctl_chain[MAX_PARTS].valid && ctl_chain[MAX_PARTS].last;
            src_ctl_reg.valid <= src_run_reg;
            src_ctl_reg.first <= (src_idx_reg == '0);
            src_ctl_reg.last  <= src_last;
            if (accept)
            begin
                busy_reg    <= 1'b1;
                src_run_reg <= 1'b1;
            end
            else
            begin
                if (src_run_reg && src_last)
                begin
                    src_run_reg <= 1'b0;
                end
                if (ctl_chain[MAX_PARTS].valid && ctl_chain[MAX_PARTS].last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Item parameters and source row: 1, 0, 0, ... over m+1 elements.
    always_ff @(posedge clk)
    begin
        src_val_reg <= (src_idx_reg == '0) ? count_t'(1) : '0;
        if (accept)
        begin
            src_idx_reg <= '0;
            zero_reg    <= bad_req;
            m_reg       <= bad_req ? '0 : IW'(total - {5'b0, parts});
            parts_reg   <= bad_req ? '0 : parts;
        end
        else if (src_run_reg && !src_last)
        begin
            src_idx_reg <= src_idx_reg + 1'b1;
        end
        if (ctl_chain[MAX_PARTS].valid && ctl_chain[MAX_PARTS].last)
        begin
            count_reg <= zero_reg ? '0 : val_chain[MAX_PARTS];
        end
    end

    assign ctl_chain[0] = src_ctl_reg;
    assign val_chain[0] = src_val_reg;

    // Cell g+1 folds in parts of size g+1; cells above parts pass through.
    for (genvar g = 0; g < MAX_PARTS; g++)
    begin : g_cell
        pcep_cell #(
            .J (g + 1)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .parts   (parts_reg),
            .ctl_in  (ctl_chain[g]),
            .val_in  (val_chain[g]),
            .ctl_out (ctl_chain[g+1]),
            .val_out (val_chain[g+1])
        );
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign count = count_reg;

`include "partition_count_exact_parts_assert.svh"

    `PCEP_ASSERT_NEXT(a_accept_busy, accept, busy_reg)
    `PCEP_ASSERT_NOW(a_done_after_busy, done_reg, $past(busy_reg) && !busy_reg)
    `PCEP_ASSERT_NOW(a_bad_zero, done_reg && zero_reg, count_reg == '0)
    `PCEP_ASSERT_NOW(a_idle_quiet, !busy_reg, !src_run_reg && !src_ctl_reg.valid)

endmodule

// ===== design/pcep_cell.sv =====
// One part-size cell: out[i] = in[i] + out[i-J] when enabled, else out[i] = in[i].
module pcep_cell
    import pcep_pkg::*;
#(
    parameter int J = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PARTS_W-1:0] parts,
    input  pcep_ctl_t          ctl_in,
    input  count_t             val_in,
    output pcep_ctl_t          ctl_out,
    output count_t             val_out
);

    localparam int FW = $clog2(J + 1);
    localparam logic [FW-1:0] FULL = FW'(J);

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    count_t        dly_reg [J];
    pcep_ctl_t     ctl_reg;
    count_t        val_reg;
    logic          active;
    logic          use_dly;
    count_t        sum;

    always_comb
    begin
        active    = (32'(parts) >= J);
        use_dly   = active && !ctl_in.first && (fill_reg == FULL);
        sum       = val_in + (use_dly ? dly_reg[J-1] : '0);
        if (ctl_in.first)
        begin
            fill_next = FW'(1);
        end
        else if (fill_reg == FULL)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
            if (ctl_in.valid)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Delay line holds the last J outputs of this cell.
    always_ff @(posedge clk)
    begin
        if (ctl_in.valid)
        begin
            val_reg    <= sum;
            dly_reg[0] <= sum;
            for (int k = 1; k < J; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign val_out = val_reg;

endmodule

// ===== tb/partition_count_exact_parts_tb.sv =====
module partition_count_exact_parts_tb;
    import pcep_pkg::*;

    // Parts code above the hardware bound; the block must answer zero.
    localparam logic [PARTS_W-1:0] PARTS_ABOVE_MAX = 3'd7;

    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 306;
    // Slowest run: 330 items, each busy for the longest row plus the longest gap; keep ample margin.
    localparam int CYCLE_LIMIT   = 800000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [TOTAL_W-1:0] total = '0;
    logic [PARTS_W-1:0] parts = '0;
    logic               busy;
    logic               done;
    logic [COUNT_W-1:0] count;

    // Counts still owed by the block, oldest first.
    count_t pending_counts[$];
    int     mismatches = 0;
    int     cycle_count = 0;

    // Directed stimulus row; 'typed' rows carry an answer known on sight,
    // the rest fall back to the partition predictor.
    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic [PARTS_W-1:0] parts;
        bit                 typed;
        count_t             count;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'd0,   3'd0,            1'b1, 32'd1},  // empty sum is the one way to split zero
        '{8'd5,   3'd0,            1'b1, 32'd0},  // zero parts, nonzero total
        '{8'd255, 3'd0,            1'b1, 32'd0},
        '{8'd0,   PARTS_ABOVE_MAX, 1'b1, 32'd0},  // parts above bound
        '{8'd255, PARTS_ABOVE_MAX, 1'b1, 32'd0},
        '{8'd85,  PARTS_ABOVE_MAX, 1'b1, 32'd0},
        '{8'd3,   3'd4,            1'b1, 32'd0},  // more parts than total
        '{8'd0,   3'd1,            1'b1, 32'd0},
        '{8'd5,   3'd6,            1'b1, 32'd0},
        '{8'd6,   3'd6,            1'b1, 32'd1},  // parts equal total
        '{8'd1,   3'd1,            1'b1, 32'd1},
        '{8'd255, 3'd1,            1'b1, 32'd1},  // single part, longest row
        '{8'd170, 3'd1,            1'b1, 32'd1},
        '{8'd255, 3'd6,            1'b0, 32'd0},  // largest count at defaults
        '{8'd255, 3'd5,            1'b0, 32'd0},
        '{8'd255, 3'd2,            1'b0, 32'd0},
        '{8'd254, 3'd3,            1'b0, 32'd0},
        '{8'd10,  3'd3,            1'b0, 32'd0},
        '{8'd7,   3'd2,            1'b0, 32'd0},
        '{8'd8,   3'd4,            1'b0, 32'd0},
        '{8'd6,   3'd5,            1'b0, 32'd0},
        '{8'd12,  3'd6,            1'b0, 32'd0},
        '{8'd170, 3'd4,            1'b0, 32'd0},
        '{8'd85,  3'd5,            1'b0, 32'd0}
    };

    partition_count_exact_parts u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .total (total),
        .parts (parts),
        .busy  (busy),
        .done  (done),
        .count (count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Partitions of t into exactly p positive parts, via the equivalent count
    // of partitions of t - p into parts no larger than p. One row, 32-bit wrap.
    function automatic count_t partitions_exact(input logic [TOTAL_W-1:0] t,
                                                input logic [PARTS_W-1:0] p);
        count_t row [0:PCEP_MAX_TOTAL];
        int     span;
        if (p > PCEP_MAX_PARTS || t > PCEP_MAX_TOTAL || p > t)
            return '0;
        span = t - p;
        row[0] = 32'd1;
        for (int m = 1; m <= span; m++)
            row[m] = '0;
        for (int size = 1; size <= p; size++)
            for (int m = size; m <= span; m++)
                row[m] = row[m] + row[m - size];
        return row[span];
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0d] MISMATCH: %s", cycle_count, msg);
    endtask

    // Mostly back-to-back, some short pauses, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 80);
    endfunction

    // Presents one item from a falling edge and holds it until accepted.
    // A nonzero gap first drops start and holds it low through the gap.
    task automatic send_item(input logic [TOTAL_W-1:0] t, input logic [PARTS_W-1:0] p,
                             input int gap, input bit typed, input count_t typed_count);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        total <= t;
        parts <= p;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_counts.push_back(typed ? typed_count : partitions_exact(t, p));
    endtask

    // Result checker: every done pulse retires the oldest outstanding item.
    always @(posedge clk)
    begin : check_results
        count_t want;
        if (rst_n && done)
        begin
            if (pending_counts.size() == 0)
                report_mismatch($sformatf("count %0d with no item outstanding", count));
            else
            begin
                want = pending_counts.pop_front();
                if (count !== want)
                    report_mismatch($sformatf("count %0d, expected %0d", count, want));
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TOTAL_W-1:0] t;
        logic [PARTS_W-1:0] p;
        int                 roll;
        int                 gap;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: edges of both fields and every special case.
        foreach (directed_rows[i])
            send_item(directed_rows[i].total, directed_rows[i].parts, pick_gap(),
                      directed_rows[i].typed, directed_rows[i].count);

        // Random part: mostly well-formed requests, the rest corner codes.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Sender holds off until the block has drained everything.
            if (i % 110 == 55)
            begin
                @(negedge clk);
                start <= 1'b0;
                wait (pending_counts.size() == 0);
            end

            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                p = PARTS_W'($urandom_range(1, PCEP_MAX_PARTS));
                if ($urandom_range(0, 2) == 0)
                    t = TOTAL_W'($urandom_range(p, p + 12));
                else
                    t = TOTAL_W'($urandom_range(p, 255));
            end
            else if (roll < 78)
            begin
                p = '0;
                t = ($urandom_range(0, 3) == 0) ? '0 : TOTAL_W'($urandom_range(0, 255));
            end
            else if (roll < 86)
            begin
                p = PARTS_ABOVE_MAX;
                t = TOTAL_W'($urandom_range(0, 255));
            end
            else if (roll < 94)
            begin
                p = PARTS_W'($urandom_range(2, PCEP_MAX_PARTS));
                t = TOTAL_W'($urandom_range(0, p - 1));
            end
            else
            begin
                p = PARTS_W'($urandom_range(1, PCEP_MAX_PARTS));
                t = TOTAL_W'(p);
            end

            // Stretches of back-to-back items between the idling ones.
            gap = (i % 60 < 20) ? 0 : pick_gap();
            send_item(t, p, gap, 1'b0, '0);
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending_counts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
